FILE: src/hne_pkg.sv
// ----------------------------------------------------------------------------
// hne_pkg
// Shared sizes, action codes, microcode word and status types for the
// Hopfield network engine.
// ----------------------------------------------------------------------------
package hne_pkg;

    localparam int NEURONS     = 64;
    localparam int WEIGHT_BITS = 16;

    localparam int IDX_W      = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int ROW_W      = 6;
    localparam int VALUE_W    = 16;
    localparam int ACTION_W   = 3;
    localparam int SPIN_VEC_W = 64;
    localparam int ENERGY_W   = 29;
    localparam int WADDR_W    = $clog2(NEURONS * NEURONS);
    localparam int ACC_W      = WEIGHT_BITS + 2 * IDX_W + 2;
    localparam int UPC_W      = 4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WR_WEIGHT = 3'd0,
        ACT_WR_BIAS   = 3'd1,
        ACT_WR_SPIN   = 3'd2,
        ACT_UPDATE    = 3'd3,
        ACT_ENERGY    = 3'd4
    } action_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_WR_W,
        OP_WR_B,
        OP_WR_S,
        OP_UPD_INIT,
        OP_UPD_STEP,
        OP_UPD_FIN,
        OP_ENG_INIT,
        OP_ENG_STEP,
        OP_ENG_FIN,
        OP_RESP
    } dp_op_t;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_GOTO,
        JMP_DISPATCH,
        JMP_LOOP,
        JMP_OUT_FREE
    } jmp_t;

    typedef logic [UPC_W-1:0] upc_t;

    typedef struct packed {
        dp_op_t op;
        jmp_t   jmp;
        upc_t   target;
    } ucw_t;

    typedef struct packed {
        logic loop_last;
        logic out_free;
    } dp_stat_t;

    function automatic logic [WEIGHT_BITS-1:0] to_stored(logic signed [VALUE_W-1:0] v);
        logic signed [31:0] x;
        x = 32'(v);
        return x[WEIGHT_BITS-1:0];
    endfunction

endpackage

FILE: src/hne_if.sv
// ----------------------------------------------------------------------------
// hne_if
// Input and output item channels of the Hopfield network engine.
// ----------------------------------------------------------------------------
interface hne_in_if import hne_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic [ROW_W-1:0]           row;
    logic [ROW_W-1:0]           col;
    logic signed [VALUE_W-1:0]  value;
    logic                       spin_value;

    modport source (output valid, action, row, col, value, spin_value, input ready);
    modport sink   (input valid, action, row, col, value, spin_value, output ready);
endinterface

interface hne_out_if import hne_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [SPIN_VEC_W-1:0]      spin_vector;
    logic                       updated_spin;
    logic signed [ENERGY_W-1:0] energy;

    modport source (output valid, spin_vector, updated_spin, energy, input ready);
    modport sink   (input valid, spin_vector, updated_spin, energy, output ready);
endinterface

FILE: src/hopfield_network_engine.sv
// ----------------------------------------------------------------------------
// hopfield_network_engine
// Hopfield network with single-neuron update and energy readout.
// ----------------------------------------------------------------------------
// One item in, one result out. Each item runs a short microprogram; weight
// and bias reads go through single-port-read RAMs, one weight per cycle.
// Write weight, write bias and write spin do their write and then go to the
// response, an unknown action goes to it at once; an update walks one row of
// the weight RAM and an energy query its lower triangle, diagonal included,
// through the weight RAM read port. The response waits while the previous
// result has not been taken.
// Weights must be written before an update or energy query reads them;
// biases and spins reset to zero and -1.
// ----------------------------------------------------------------------------
module hopfield_network_engine import hne_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    hne_in_if.sink   in_ch,
    hne_out_if.source out_ch
);

    dp_op_t   op;
    dp_stat_t stat;
    logic     in_ready;

    hne_useq u_useq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .action   (in_ch.action),
        .stat     (stat),
        .in_ready (in_ready),
        .op       (op)
    );

    hne_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .row          (in_ch.row),
        .col          (in_ch.col),
        .value        (in_ch.value),
        .spin_value   (in_ch.spin_value),
        .out_ready    (out_ch.ready),
        .stat         (stat),
        .out_valid    (out_ch.valid),
        .spin_vector  (out_ch.spin_vector),
        .updated_spin (out_ch.updated_spin),
        .energy       (out_ch.energy)
    );

    assign in_ch.ready = in_ready;

endmodule

FILE: src/hne_ram.sv
// ----------------------------------------------------------------------------
// hne_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hne_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/hne_useq.sv
// ----------------------------------------------------------------------------
// hne_useq
// Microcode sequencer: control store, step counter and jump logic.
// ----------------------------------------------------------------------------
module hne_useq import hne_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [ACTION_W-1:0] action,
    input  dp_stat_t            stat,
    output logic                in_ready,
    output dp_op_t              op
);

    localparam upc_t UA_FETCH     = 4'd0;
    localparam upc_t UA_WR_W      = 4'd1;
    localparam upc_t UA_WR_B      = 4'd2;
    localparam upc_t UA_WR_S      = 4'd3;
    localparam upc_t UA_UPD_INIT  = 4'd4;
    localparam upc_t UA_UPD_LOOP  = 4'd5;
    localparam upc_t UA_UPD_DRAIN = 4'd6;
    localparam upc_t UA_UPD_FIN   = 4'd7;
    localparam upc_t UA_ENG_INIT  = 4'd8;
    localparam upc_t UA_ENG_LOOP  = 4'd9;
    localparam upc_t UA_ENG_DRAIN = 4'd10;
    localparam upc_t UA_ENG_FIN   = 4'd11;
    localparam upc_t UA_RESP      = 4'd12;

    function automatic ucw_t ucode(upc_t a);
        ucw_t w;
        unique case (a)
            UA_FETCH:     w = '{OP_ACCEPT,   JMP_DISPATCH, UA_FETCH};
            UA_WR_W:      w = '{OP_WR_W,     JMP_GOTO,     UA_RESP};
            UA_WR_B:      w = '{OP_WR_B,     JMP_GOTO,     UA_RESP};
            UA_WR_S:      w = '{OP_WR_S,     JMP_GOTO,     UA_RESP};
            UA_UPD_INIT:  w = '{OP_UPD_INIT, JMP_NEXT,     UA_FETCH};
            UA_UPD_LOOP:  w = '{OP_UPD_STEP, JMP_LOOP,     UA_UPD_LOOP};
            UA_UPD_DRAIN: w = '{OP_NOP,      JMP_NEXT,     UA_FETCH};
            UA_UPD_FIN:   w = '{OP_UPD_FIN,  JMP_GOTO,     UA_RESP};
            UA_ENG_INIT:  w = '{OP_ENG_INIT, JMP_NEXT,     UA_FETCH};
            UA_ENG_LOOP:  w = '{OP_ENG_STEP, JMP_LOOP,     UA_ENG_LOOP};
            UA_ENG_DRAIN: w = '{OP_NOP,      JMP_NEXT,     UA_FETCH};
            UA_ENG_FIN:   w = '{OP_ENG_FIN,  JMP_GOTO,     UA_RESP};
            UA_RESP:      w = '{OP_RESP,     JMP_OUT_FREE, UA_FETCH};
            default:      w = '{OP_NOP,      JMP_GOTO,     UA_FETCH};
        endcase
        return w;
    endfunction

    upc_t pc_reg;
    upc_t pc_next;
    ucw_t cw;

    assign cw = ucode(pc_reg);

    always_comb
    begin
        pc_next = pc_reg;
        unique case (cw.jmp)
            JMP_NEXT:
                pc_next = pc_reg + 1'b1;
            JMP_GOTO:
                pc_next = cw.target;
            JMP_DISPATCH:
            begin
                if (in_valid)
                begin
                    unique case (action)
                        ACT_WR_WEIGHT: pc_next = UA_WR_W;
                        ACT_WR_BIAS:   pc_next = UA_WR_B;
                        ACT_WR_SPIN:   pc_next = UA_WR_S;
                        ACT_UPDATE:    pc_next = UA_UPD_INIT;
                        ACT_ENERGY:    pc_next = UA_ENG_INIT;
                        default:       pc_next = UA_RESP;
                    endcase
                end
            end
            JMP_LOOP:
                pc_next = stat.loop_last ? pc_reg + 1'b1 : cw.target;
            JMP_OUT_FREE:
                pc_next = stat.out_free ? cw.target : pc_reg;
            default:
                pc_next = UA_FETCH;
        endcase
    end

    always_comb
    begin
        op = cw.op;
        if ((cw.jmp == JMP_DISPATCH && !in_valid) || (cw.jmp == JMP_OUT_FREE && !stat.out_free))
        begin
            op = OP_NOP;
        end
    end

    assign in_ready = (cw.jmp == JMP_DISPATCH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= UA_FETCH;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

FILE: src/hne_datapath.sv
// ----------------------------------------------------------------------------
// hne_datapath
// Spin register, weight and bias RAMs, walk counters, accumulator and
// output register, driven one micro-op per cycle.
// ----------------------------------------------------------------------------
module hne_datapath import hne_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  dp_op_t                     op,
    input  logic [ROW_W-1:0]           row,
    input  logic [ROW_W-1:0]           col,
    input  logic signed [VALUE_W-1:0]  value,
    input  logic                       spin_value,
    input  logic                       out_ready,
    output dp_stat_t                   stat,
    output logic                       out_valid,
    output logic [SPIN_VEC_W-1:0]      spin_vector,
    output logic                       updated_spin,
    output logic signed [ENERGY_W-1:0] energy
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NEURONS - 1);

    logic [ROW_W-1:0]           row_reg;
    logic [ROW_W-1:0]           col_reg;
    logic signed [VALUE_W-1:0]  value_reg;
    logic                       spin_in_reg;

    logic [NEURONS-1:0]         spin_reg,     spin_next;
    logic [NEURONS-1:0]         bias_vld_reg, bias_vld_next;
    logic                       bvld_q_reg;
    logic [IDX_W-1:0]           i_reg,        i_next;
    logic [IDX_W-1:0]           j_reg,        j_next;
    logic                       rd_vld_reg,   rd_vld_next;
    logic                       rd_eng_reg,   rd_eng_next;
    logic [IDX_W-1:0]           rd_i_reg,     rd_i_next;
    logic [IDX_W-1:0]           rd_j_reg,     rd_j_next;
    logic signed [ACC_W-1:0]    acc_reg,      acc_next;
    logic                       upd_res_reg,  upd_res_next;
    logic [ENERGY_W-1:0]        eng_res_reg,  eng_res_next;
    logic                       out_vld_reg,  out_vld_next;
    logic [SPIN_VEC_W-1:0]      out_spin_reg, out_spin_next;
    logic                       out_upd_reg,  out_upd_next;
    logic [ENERGY_W-1:0]        out_eng_reg,  out_eng_next;

    logic                       row_ok;
    logic                       col_ok;
    logic [IDX_W-1:0]           row_idx;
    logic [IDX_W-1:0]           col_idx;
    logic [IDX_W-1:0]           i_sel;
    logic [WEIGHT_BITS-1:0]     stored_val;

    logic                       w_we;
    logic [WADDR_W-1:0]         w_waddr;
    logic [WADDR_W-1:0]         w_raddr;
    logic [WEIGHT_BITS-1:0]     w_rdata;
    logic                       b_we;
    logic [WEIGHT_BITS-1:0]     b_rdata;

    logic signed [ACC_W-1:0]    w_ext;
    logic signed [ACC_W-1:0]    b_ext;
    logic signed [ACC_W-1:0]    term_a;
    logic signed [ACC_W-1:0]    term_b;
    logic signed [ACC_W+ENERGY_W-1:0] acc_wide;
    logic                       s_i;
    logic                       s_j;

    assign row_ok     = ({1'b0, row_reg} < (ROW_W + 1)'(NEURONS));
    assign col_ok     = ({1'b0, col_reg} < (ROW_W + 1)'(NEURONS));
    assign row_idx    = row_reg[IDX_W-1:0];
    assign col_idx    = col_reg[IDX_W-1:0];
    assign i_sel      = (op == OP_ENG_STEP) ? i_reg : row_idx;
    assign stored_val = to_stored(value_reg);

    assign w_we    = (op == OP_WR_W) && row_ok && col_ok;
    assign w_waddr = WADDR_W'(row_idx) * WADDR_W'(NEURONS) + WADDR_W'(col_idx);
    assign w_raddr = WADDR_W'(i_sel) * WADDR_W'(NEURONS) + WADDR_W'(j_reg);
    assign b_we    = (op == OP_WR_B) && row_ok;

    hne_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (NEURONS * NEURONS)
    ) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (stored_val),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    hne_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (NEURONS)
    ) u_bias_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (row_idx),
        .wdata (stored_val),
        .raddr (i_sel),
        .rdata (b_rdata)
    );

    assign w_ext = ACC_W'(signed'(w_rdata));
    assign b_ext = bvld_q_reg ? ACC_W'(signed'(b_rdata)) : '0;
    assign s_i   = spin_reg[rd_i_reg];
    assign s_j   = spin_reg[rd_j_reg];

    // term selection for the item in the read stage
    always_comb
    begin
        term_a = '0;
        term_b = '0;
        if (rd_vld_reg)
        begin
            if (!rd_eng_reg)
            begin
                if (rd_j_reg != rd_i_reg)
                begin
                    term_a = s_j ? w_ext : -w_ext;
                end
            end
            else if (rd_j_reg == rd_i_reg)
            begin
                term_a = s_i ? (b_ext <<< 1) : -(b_ext <<< 1);
                term_b = -w_ext;
            end
            else
            begin
                term_a = (s_i ^ s_j) ? (w_ext <<< 1) : -(w_ext <<< 1);
            end
        end
    end

    assign acc_wide = (ACC_W + ENERGY_W)'(acc_reg);

    always_comb
    begin
        spin_next     = spin_reg;
        bias_vld_next = bias_vld_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        rd_vld_next   = 1'b0;
        rd_eng_next   = rd_eng_reg;
        rd_i_next     = rd_i_reg;
        rd_j_next     = rd_j_reg;
        acc_next      = acc_reg + term_a + term_b;
        upd_res_next  = upd_res_reg;
        eng_res_next  = eng_res_reg;
        out_vld_next  = out_vld_reg && !out_ready;
        out_spin_next = out_spin_reg;
        out_upd_next  = out_upd_reg;
        out_eng_next  = out_eng_reg;

        unique case (op)
            OP_ACCEPT:
            begin
                upd_res_next = 1'b0;
                eng_res_next = '0;
            end
            OP_WR_B:
            begin
                if (row_ok)
                begin
                    bias_vld_next[row_idx] = 1'b1;
                end
            end
            OP_WR_S:
            begin
                if (row_ok)
                begin
                    spin_next[row_idx] = spin_in_reg;
                end
            end
            OP_UPD_INIT:
            begin
                acc_next = '0;
                j_next   = '0;
            end
            OP_UPD_STEP:
            begin
                rd_vld_next = 1'b1;
                rd_eng_next = 1'b0;
                rd_i_next   = row_idx;
                rd_j_next   = j_reg;
                j_next      = j_reg + 1'b1;
            end
            OP_UPD_FIN:
            begin
                if (row_ok)
                begin
                    upd_res_next       = (acc_reg > b_ext);
                    spin_next[row_idx] = (acc_reg > b_ext);
                end
            end
            OP_ENG_INIT:
            begin
                acc_next = '0;
                i_next   = '0;
                j_next   = '0;
            end
            OP_ENG_STEP:
            begin
                rd_vld_next = 1'b1;
                rd_eng_next = 1'b1;
                rd_i_next   = i_reg;
                rd_j_next   = j_reg;
                if (j_reg == i_reg)
                begin
                    i_next = i_reg + 1'b1;
                    j_next = '0;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            OP_ENG_FIN:
                eng_res_next = acc_wide[ENERGY_W-1:0];
            OP_RESP:
            begin
                out_vld_next  = 1'b1;
                out_spin_next = SPIN_VEC_W'(spin_reg);
                out_upd_next  = upd_res_reg;
                out_eng_next  = eng_res_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (op == OP_ACCEPT)
        begin
            row_reg     <= row;
            col_reg     <= col;
            value_reg   <= value;
            spin_in_reg <= spin_value;
        end
        bvld_q_reg    <= bias_vld_reg[i_sel];
        rd_eng_reg    <= rd_eng_next;
        rd_i_reg      <= rd_i_next;
        rd_j_reg      <= rd_j_next;
        acc_reg       <= acc_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        out_spin_reg  <= out_spin_next;
        out_upd_reg   <= out_upd_next;
        out_eng_reg   <= out_eng_next;
        upd_res_reg   <= upd_res_next;
        eng_res_reg   <= eng_res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spin_reg     <= '0;
            bias_vld_reg <= '0;
            rd_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            spin_reg     <= spin_next;
            bias_vld_reg <= bias_vld_next;
            rd_vld_reg   <= rd_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    assign stat.loop_last = (op == OP_ENG_STEP) ? (i_reg == LAST_IDX && j_reg == LAST_IDX)
                                                : (j_reg == LAST_IDX);
    assign stat.out_free  = !out_vld_reg || out_ready;

    assign out_valid    = out_vld_reg;
    assign spin_vector  = out_spin_reg;
    assign updated_spin = out_upd_reg;
    assign energy       = out_eng_reg;

endmodule
